>>> hw/rtl/mbe_pkg.sv
// Package for the monochrome bitmap expander: job type passed from front to back
// and header layout constants. No dependencies.
package mbe_pkg;

  // Header layout
  localparam int unsigned HdrLen = 8;

  typedef logic [3:0] hdr_idx_t;

  localparam hdr_idx_t HdrWidthHi  = 4'd0;
  localparam hdr_idx_t HdrWidthLo  = 4'd1;
  localparam hdr_idx_t HdrHeightHi = 4'd2;
  localparam hdr_idx_t HdrHeightLo = 4'd3;
  localparam hdr_idx_t HdrRed      = 4'd4;
  localparam hdr_idx_t HdrGreen    = 4'd5;
  localparam hdr_idx_t HdrBlue     = 4'd6;
  localparam hdr_idx_t HdrPad      = 4'd7;
  localparam hdr_idx_t HdrDone     = 4'd8;

  localparam int unsigned BitsPerByte = 8;

  // One bitmap byte worth of drawing work
  typedef struct packed {
    logic [7:0]  mask;   // bit 7 is column x0
    logic [15:0] x0;
    logic [15:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } job_t;

endpackage

>>> hw/rtl/mbe_if.sv
// Channel interfaces of the bitmap expander: image byte words in, pixel words out.
// No dependencies.
interface mbe_byte_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [7:0]  data_byte;

  modport source (output valid, first, origin_x, origin_y, data_byte, input ready);
  modport sink   (input valid, first, origin_x, origin_y, data_byte, output ready);
endinterface

interface mbe_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, last, output ready);
endinterface

>>> hw/rtl/mbe_front.sv
// Front end: takes image bytes, parses the header, tracks column and row and
// turns each drawable bitmap byte into a job. Depends on mbe_pkg.
module mbe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          first_i,
  input  logic [15:0]   origin_x_i,
  input  logic [15:0]   origin_y_i,
  input  logic [7:0]    data_byte_i,
  output logic          push_o,
  output mbe_pkg::job_t job_o,
  input  logic          full_i
);
  import mbe_pkg::*;

  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [15:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic [15:0] col_q, col_d, row_q, row_d;

  logic        accept;
  logic [3:0]  hdr_cnt;
  logic [15:0] w_eff, h_eff;
  logic [16:0] rem;
  logic [7:0]  col_ok, mask;
  logic        row_ok, wrap;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;

  // first restarts the header and samples the origin
  assign hdr_cnt = first_i ? HdrWidthHi : hdr_cnt_q;

  // Sizes with bit 15 set count as zero
  assign w_eff = width_q[15]  ? 16'd0 : width_q;
  assign h_eff = height_q[15] ? 16'd0 : height_q;
  assign row_ok = row_q < h_eff;

  // Columns left in this row; bit k (MSB first) is drawable when k < rem
  assign rem = {1'b0, w_eff} - {1'b0, col_q};
  always_comb begin
    if (rem[16]) begin
      col_ok = 8'h00;
    end else if (rem[15:3] != 13'd0) begin
      col_ok = 8'hFF;
    end else begin
      col_ok = ~(8'hFF >> rem[2:0]);
    end
  end
  assign wrap = rem[16] | (rem <= 17'(BitsPerByte));
  assign mask = col_ok & data_byte_i;

  // Job to the queue
  assign push_o      = accept & (hdr_cnt == HdrDone) & row_ok & (mask != 8'h00);
  assign job_o.mask  = mask;
  assign job_o.x0    = base_x_q + col_q;
  assign job_o.y     = base_y_q + row_q;
  assign job_o.red   = red_q;
  assign job_o.green = green_q;
  assign job_o.blue  = blue_q;

  // Header parsing and position tracking
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    width_d   = width_q;
    height_d  = height_q;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    base_x_d  = base_x_q;
    base_y_d  = base_y_q;
    col_d     = col_q;
    row_d     = row_q;
    if (accept) begin
      if (first_i) begin
        base_x_d = origin_x_i;
        base_y_d = origin_y_i;
      end
      if (hdr_cnt != HdrDone) begin
        hdr_cnt_d = hdr_cnt + 4'd1;
        unique case (hdr_cnt)
          HdrWidthHi: begin
            width_d = {data_byte_i, 8'h00};
            col_d   = '0;
            row_d   = '0;
          end
          HdrWidthLo:  width_d  = {width_q[15:8], data_byte_i};
          HdrHeightHi: height_d = {data_byte_i, 8'h00};
          HdrHeightLo: height_d = {height_q[15:8], data_byte_i};
          HdrRed:      red_d    = data_byte_i;
          HdrGreen:    green_d  = data_byte_i;
          HdrBlue:     blue_d   = data_byte_i;
          default: ;   // pad byte
        endcase
      end else if (row_ok) begin
        if (wrap) begin
          col_d = '0;
          row_d = row_q + 16'd1;
        end else begin
          col_d = col_q + 16'(BitsPerByte);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      width_q   <= '0;
      height_q  <= '0;
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
      base_x_q  <= '0;
      base_y_q  <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      width_q   <= width_d;
      height_q  <= height_d;
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      base_x_q  <= base_x_d;
      base_y_q  <= base_y_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

endmodule

>>> hw/rtl/mbe_queue.sv
// Short job queue between front and back end, register based.
// Depends on mbe_pkg.
module mbe_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbe_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mbe_pkg::job_t job_o
);
  import mbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hw/rtl/mbe_back.sv
// Back end: takes jobs from the queue and emits one pixel word per set mask
// bit, MSB first, through an output register. Depends on mbe_pkg.
module mbe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mbe_pkg::job_t job_i,
  output logic          pop_o,
  output logic          pix_valid_o,
  input  logic          pix_ready_i,
  output logic [15:0]   pixel_x_o,
  output logic [15:0]   pixel_y_o,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic          last_o
);
  import mbe_pkg::*;

  job_t        job_q, job_d;
  logic        out_vld_q, out_vld_d;
  logic [15:0] x_q, y_q;
  logic [7:0]  r_q, g_q, b_q;
  logic        last_q;

  logic        advance, emit;
  logic [2:0]  hi;
  logic [7:0]  rest;
  logic [15:0] x_pix;

  // Highest set mask bit is the leftmost pixel still to draw
  always_comb begin
    hi = 3'd0;
    for (int i = 0; i < BitsPerByte; i++) begin
      if (job_q.mask[i]) begin
        hi = 3'(i);
      end
    end
  end
  assign rest  = job_q.mask & ~(8'h01 << hi);
  assign x_pix = job_q.x0 + {13'd0, 3'd7 - hi};

  assign advance = ~out_vld_q | pix_ready_i;
  assign emit    = advance & (job_q.mask != 8'h00);
  assign pop_o   = job_valid_i & ((job_q.mask == 8'h00) | (emit & (rest == 8'h00)));

  // Job register
  always_comb begin
    job_d = job_q;
    if (pop_o) begin
      job_d = job_i;
    end else if (emit) begin
      job_d.mask = rest;
    end
  end

  assign out_vld_d = emit | (out_vld_q & ~pix_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      job_q     <= job_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      x_q    <= x_pix;
      y_q    <= job_q.y;
      r_q    <= job_q.red;
      g_q    <= job_q.green;
      b_q    <= job_q.blue;
      last_q <= rest == 8'h00;
    end
  end

  assign pix_valid_o = out_vld_q;
  assign pixel_x_o   = x_q;
  assign pixel_y_o   = y_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;
  assign last_o      = last_q;

endmodule

>>> hw/rtl/mono_bitmap_expander_core.sv
// Monochrome bitmap expander, top level.
// Depends on mbe_pkg, mbe_if, mbe_front, mbe_queue and mbe_back.
//
// byte_i carries the image stream, one byte per word. A word with first set
// starts an image and samples origin_x/origin_y; it and the next seven words are
// the header (width, height big-endian, red, green, blue, pad). Later words are
// bitmap bytes, rows padded to whole bytes. pix_o carries one word per drawn
// pixel, MSB first within each byte, with last set on the final pixel of a byte.
// Throughput: the front end takes one byte per cycle while the queue is not full; the
// back end emits one pixel per cycle while pix_o is ready, so a byte with n drawn
// pixels gives n words (up to 8). A job reaching an idle back end first loads the job
// register. On an idle core a bitmap byte reaches its first pixel via the queue, which
// takes the job at the accepting edge, then the job register, then the output register.
// byte_i is held off only when the job queue (QueueDepth entries) is full; header
// bytes and bytes that draw nothing still need a free slot to be taken.
// When pix_o stalls, the output register holds its word and jobs pile up in the
// queue until it fills. Reset empties queue and output and clears the header
// state, so bytes seen without first are parsed as header with origin zero.
module mono_bitmap_expander_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mbe_byte_if.sink  byte_i,
  mbe_pix_if.source pix_o
);
  import mbe_pkg::*;

  logic push, full, pop, job_valid;
  job_t job_in, job_out;

  mbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .in_ready_o  (byte_i.ready),
    .first_i     (byte_i.first),
    .origin_x_i  (byte_i.origin_x),
    .origin_y_i  (byte_i.origin_y),
    .data_byte_i (byte_i.data_byte),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  mbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  mbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .pix_valid_o (pix_o.valid),
    .pix_ready_i (pix_o.ready),
    .pixel_x_o   (pix_o.pixel_x),
    .pixel_y_o   (pix_o.pixel_y),
    .red_o       (pix_o.red),
    .green_o     (pix_o.green),
    .blue_o      (pix_o.blue),
    .last_o      (pix_o.last)
  );

endmodule
